[rtl/tdd_pkg.sv]
// Shared types and constants for the telemetry datagram deframer.
package tdd_pkg;

  localparam int unsigned V2MaxSize = 1024;

  localparam logic [3:0] TAG_DESC   = 4'd0;
  localparam logic [3:0] TAG_STRING = 4'd1;
  localparam logic [3:0] TAG_MODULE = 4'd2;
  localparam logic [3:0] TAG_LEVEL  = 4'd3;
  localparam logic [3:0] TAG_FUNC   = 4'd4;
  localparam logic [3:0] TAG_ELEM   = 4'd5;
  localparam logic [3:0] TAG_VALUE  = 4'd6;
  localparam logic [3:0] TAG_STATE  = 4'd7;
  localparam logic [3:0] TAG_SECS   = 4'd8;
  localparam logic [3:0] TAG_NANOS  = 4'd9;
  localparam logic [3:0] TAG_END    = 4'd10;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_VERSION   = 4'd1;
  localparam logic [3:0] ST_SHORT     = 4'd2;
  localparam logic [3:0] ST_TOO_LARGE = 4'd3;
  localparam logic [3:0] ST_TYPE      = 4'd4;
  localparam logic [3:0] ST_FLAGS     = 4'd5;
  localparam logic [3:0] ST_HDR_LEN   = 4'd6;
  localparam logic [3:0] ST_TOTAL_LEN = 4'd7;
  localparam logic [3:0] ST_TIMESTAMP = 4'd8;
  localparam logic [3:0] ST_FIELD_LEN = 4'd9;
  localparam logic [3:0] ST_STR_LONG  = 4'd10;

  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_ONE  = 2'd1;
  localparam logic [1:0] FMT_TWO  = 2'd2;

  localparam logic [7:0] REG_V1_CODE  = 8'd0;
  localparam logic [7:0] REG_V2_CODE  = 8'd1;
  localparam logic [7:0] REG_NUM_CODE = 8'd2;
  localparam logic [7:0] REG_STR_CODE = 8'd3;

  typedef struct packed {
    logic [7:0] v1_code;
    logic [7:0] v2_code;
    logic [7:0] num_code;
    logic [7:0] str_code;
  } cfg_t;

  // One queue entry: an optional streamed byte and an optional end of frame.
  typedef struct packed {
    logic             has_byte;
    logic             byte_is_str;
    logic [7:0]       data;
    logic             is_end;
    logic [1:0]       fmt;
    logic             is_num;
    logic             is_str;
    logic [16:0]      size;
    logic [15:0]      flags;
    logic [15:0]      total;
    logic [15:0]      hdr;
    logic [3:0][31:0] keys;
    logic [63:0]      secs;
    logic [31:0]      nanos;
    logic [15:0]      dlen;
    logic [15:0]      vlen;
    logic [31:0]      nval;
    logic [31:0]      nstate;
    logic [6:0]       ccount;
  } entry_t;

endpackage

[rtl/telemetry_datagram_deframer.sv]
// Top level of the telemetry datagram deframer.
//
//  channel  dir  handshake                  beat
//  input    in   push / full                data_byte_i, last_byte_i
//  result   out  empty / pop                tag_o, word_o, status_o, format_o,
//                                           is_string_o, last_o
//  config   in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte accepted per cycle while full is low; a streamed byte passes through the queue and the output register.
// The closing byte expands into up to ten result beats, one per cycle unless the output stalls,
// issued by the back end from a two-entry queue; full rises once both entries are held.
// Reset restores the register defaults and clears all frame state.
// Either side may stall at any time; the output register decouples them.
module telemetry_datagram_deframer import tdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  tag_o,
  output logic [63:0] word_o,
  output logic [3:0]  status_o,
  output logic [1:0]  format_o,
  output logic        is_string_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t   cfg_q;
  entry_t wr_entry, head;
  logic   wr, head_pop, q_empty, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.v1_code  <= 8'd1;
      cfg_q.v2_code  <= 8'd2;
      cfg_q.num_code <= 8'd1;
      cfg_q.str_code <= 8'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_V1_CODE:  cfg_q.v1_code  <= cfg_data_i;
        REG_V2_CODE:  cfg_q.v2_code  <= cfg_data_i;
        REG_NUM_CODE: cfg_q.num_code <= cfg_data_i;
        REG_STR_CODE: cfg_q.str_code <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tdd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .wr_o        (wr),
    .entry_o     (wr_entry)
  );

  tdd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_data_i (wr_entry),
    .rd_i      (head_pop),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  tdd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .tag_o        (tag_o),
    .word_o       (word_o),
    .status_o     (status_o),
    .format_o     (format_o),
    .is_string_o  (is_string_o),
    .last_o       (last_o)
  );

endmodule

[rtl/tdd_front.sv]
// Front end: byte capture, field extraction and entry generation.
module tdd_front import tdd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       wr_o,
  output entry_t     entry_o
);

  logic [15:0]      cnt_q, cnt_d;
  logic             over_q, over_d;
  logic [7:0]       ver_q, ver_d, typ_q, typ_d;
  logic [15:0]      flags_q, flags_d, total_q, total_d, hdr_q, hdr_d;
  logic [3:0][31:0] keys_q, keys_d;
  logic [63:0]      secs_q, secs_d;
  logic [31:0]      nanos_q, nanos_d, nval_q, nval_d, nstate_q, nstate_d;
  logic [15:0]      dlen_q, dlen_d, vlen_q, vlen_d;
  logic             term_q, term_d;
  logic [6:0]       cc_q, cc_d;

  logic [1:0]  fmt_cur, fmt_end;
  logic        num_cur, str_cur, num_end, str_end;
  logic        emit, emit_str;
  logic [15:0] idx, idx_m2, idx_m8, off, off2;
  logic [1:0]  slot;
  logic [7:0]  b;

  always_comb begin
    fmt_cur = (ver_q == cfg_i.v1_code) ? FMT_ONE :
              (ver_q == cfg_i.v2_code) ? FMT_TWO : FMT_NONE;
    num_cur = (typ_q == cfg_i.num_code);
    str_cur = !num_cur && (typ_q == cfg_i.str_code);
    fmt_end = (ver_d == cfg_i.v1_code) ? FMT_ONE :
              (ver_d == cfg_i.v2_code) ? FMT_TWO : FMT_NONE;
    num_end = (typ_d == cfg_i.num_code);
    str_end = !num_end && (typ_d == cfg_i.str_code);
  end

  assign b      = data_byte_i;
  assign idx    = cnt_q;
  assign idx_m2 = idx - 16'd2;
  assign idx_m8 = idx - 16'd8;
  assign off    = idx - 16'd40;
  assign off2   = off - dlen_q;

  // format one key order: module, function, element, level
  always_comb begin
    unique case (idx_m2[3:2])
      2'd0:    slot = 2'd0;
      2'd1:    slot = 2'd2;
      2'd2:    slot = 2'd3;
      default: slot = 2'd1;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; over_d = over_q; ver_d = ver_q; typ_d = typ_q;
    flags_d = flags_q; total_d = total_q; hdr_d = hdr_q; keys_d = keys_q;
    secs_d = secs_q; nanos_d = nanos_q; nval_d = nval_q; nstate_d = nstate_q;
    dlen_d = dlen_q; vlen_d = vlen_q; term_d = term_q; cc_d = cc_q;
    emit = 1'b0; emit_str = 1'b0;
    if (!over_q) begin
      if (idx == 16'd0) begin
        ver_d = b;
      end else if (idx == 16'd1) begin
        typ_d = b;
      end else if (fmt_cur == FMT_ONE) begin
        if (idx < 16'd18) begin
          keys_d[slot] = {keys_q[slot][23:0], b};
        end else begin
          if (idx < 16'd22) nval_d = {nval_q[23:0], b};
          else if (idx < 16'd26) nstate_d = {nstate_q[23:0], b};
          if (!term_q) begin
            if (b == 8'd0) begin
              term_d = 1'b1;
            end else begin
              if (cc_q != 7'h7F) cc_d = cc_q + 7'd1;
              if (str_cur) begin
                emit = 1'b1; emit_str = 1'b1;
              end
            end
          end
        end
      end else if (fmt_cur == FMT_TWO) begin
        if (idx < 16'd4) flags_d = {flags_q[7:0], b};
        else if (idx < 16'd6) total_d = {total_q[7:0], b};
        else if (idx < 16'd8) hdr_d = {hdr_q[7:0], b};
        else if (idx < 16'd24) keys_d[idx_m8[3:2]] = {keys_q[idx_m8[3:2]][23:0], b};
        else if (idx < 16'd32) secs_d = {secs_q[55:0], b};
        else if (idx < 16'd36) nanos_d = {nanos_q[23:0], b};
        else if (idx < 16'd38) dlen_d = {dlen_q[7:0], b};
        else if (idx < 16'd40) vlen_d = {vlen_q[7:0], b};
        else if (off < dlen_q) emit = 1'b1;
        else if (off2 < vlen_q) begin
          if (num_cur) begin
            if (off2 < 16'd4) nval_d = {nval_q[23:0], b};
            else if (off2 < 16'd8) nstate_d = {nstate_q[23:0], b};
          end else if (str_cur) begin
            emit = 1'b1; emit_str = 1'b1;
          end
        end
      end
      if (cnt_q == 16'hFFFF) over_d = 1'b1;
      else cnt_d = cnt_q + 16'd1;
    end
  end

  always_comb begin
    wr_o                 = accept_i && (emit || last_byte_i);
    entry_o.has_byte     = emit;
    entry_o.byte_is_str  = emit_str;
    entry_o.data         = b;
    entry_o.is_end       = last_byte_i;
    entry_o.fmt          = fmt_end;
    entry_o.is_num       = num_end;
    entry_o.is_str       = str_end;
    entry_o.size         = over_d ? 17'h10000 : {1'b0, cnt_d};
    entry_o.flags        = flags_d;
    entry_o.total        = total_d;
    entry_o.hdr          = hdr_d;
    entry_o.keys         = keys_d;
    entry_o.secs         = secs_d;
    entry_o.nanos        = nanos_d;
    entry_o.dlen         = dlen_d;
    entry_o.vlen         = vlen_d;
    entry_o.nval         = nval_d;
    entry_o.nstate       = nstate_d;
    entry_o.ccount       = cc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; over_q <= 1'b0; ver_q <= '0; typ_q <= '0;
      flags_q <= '0; total_q <= '0; hdr_q <= '0; keys_q <= '0;
      secs_q <= '0; nanos_q <= '0; nval_q <= '0; nstate_q <= '0;
      dlen_q <= '0; vlen_q <= '0; term_q <= 1'b0; cc_q <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        cnt_q <= '0; over_q <= 1'b0; ver_q <= '0; typ_q <= '0;
        flags_q <= '0; total_q <= '0; hdr_q <= '0; keys_q <= '0;
        secs_q <= '0; nanos_q <= '0; nval_q <= '0; nstate_q <= '0;
        dlen_q <= '0; vlen_q <= '0; term_q <= 1'b0; cc_q <= '0;
      end else begin
        cnt_q <= cnt_d; over_q <= over_d; ver_q <= ver_d; typ_q <= typ_d;
        flags_q <= flags_d; total_q <= total_d; hdr_q <= hdr_d; keys_q <= keys_d;
        secs_q <= secs_d; nanos_q <= nanos_d; nval_q <= nval_d; nstate_q <= nstate_d;
        dlen_q <= dlen_d; vlen_q <= vlen_d; term_q <= term_d; cc_q <= cc_d;
      end
    end
  end

endmodule

[rtl/tdd_queue.sv]
// Two-entry queue between front and back end.
module tdd_queue import tdd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  entry_t wr_data_i,
  input  logic   rd_i,
  output entry_t rd_data_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= !wp_q;
      if (rd_i) rp_q <= !rp_q;
      if (wr_i && !rd_i) cnt_q <= cnt_q + 2'd1;
      else if (rd_i && !wr_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

[rtl/tdd_back.sv]
// Back end: end-of-frame checks and expansion into result beats.
module tdd_back import tdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        head_valid_i,
  output logic        head_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [3:0]  tag_o,
  output logic [63:0] word_o,
  output logic [3:0]  status_o,
  output logic [1:0]  format_o,
  output logic        is_string_o,
  output logic        last_o
);

  localparam logic signed [63:0] MinSecs  = -64'sd9223372037;
  localparam logic        [31:0] MinNanos = 32'd145224192;
  localparam logic signed [63:0] MaxSecs  = 64'sd9223372036;
  localparam logic        [31:0] MaxNanos = 32'd854775807;

  logic        active_q;
  logic [3:0]  seq_q;
  logic        oval_q;
  logic [3:0]  st;
  logic        ts_bad;
  logic [3:0]  cur, nxt;
  logic        done, adv;
  logic [63:0] word;
  logic signed [63:0] secs;

  assign secs = head_i.secs;

  always_comb begin
    ts_bad = (secs < MinSecs) || (secs == MinSecs && head_i.nanos < MinNanos) ||
             (secs > MaxSecs) || (secs == MaxSecs && head_i.nanos > MaxNanos);
    st = ST_OK;
    if (head_i.fmt == FMT_NONE) st = ST_VERSION;
    else if (head_i.fmt == FMT_ONE) begin
      if (head_i.size < 17'd18) st = ST_SHORT;
      else if (head_i.size > 17'd82) st = ST_TOO_LARGE;
      else if (!head_i.is_num && !head_i.is_str) st = ST_TYPE;
      else if (head_i.is_num) st = (head_i.size < 17'd26) ? ST_FIELD_LEN : ST_OK;
      else st = (head_i.ccount > 7'd63) ? ST_STR_LONG : ST_OK;
    end else begin
      if (head_i.size < 17'd40) st = ST_SHORT;
      else if (head_i.size > 17'(V2MaxSize)) st = ST_TOO_LARGE;
      else if (!head_i.is_num && !head_i.is_str) st = ST_TYPE;
      else if (head_i.flags != 16'd0) st = ST_FLAGS;
      else if (head_i.hdr != 16'd40) st = ST_HDR_LEN;
      else if (head_i.total > 16'(V2MaxSize)) st = ST_TOO_LARGE;
      else if (head_i.total < 16'd40 || {1'b0, head_i.total} != head_i.size)
        st = ST_TOTAL_LEN;
      else if (head_i.nanos >= 32'd1000000000) st = ST_TIMESTAMP;
      else if ({1'b0, head_i.dlen} + {1'b0, head_i.vlen} != head_i.size - 17'd40)
        st = ST_FIELD_LEN;
      else if (head_i.is_num && head_i.vlen != 16'd8) st = ST_FIELD_LEN;
      else if (ts_bad) st = ST_TIMESTAMP;
    end
  end

  always_comb begin
    if (active_q) cur = seq_q;
    else if (head_i.has_byte) cur = head_i.byte_is_str ? TAG_STRING : TAG_DESC;
    else cur = (st == ST_OK) ? TAG_MODULE : TAG_END;
    unique case (cur)
      TAG_DESC, TAG_STRING: nxt = (st == ST_OK) ? TAG_MODULE : TAG_END;
      TAG_MODULE, TAG_LEVEL, TAG_FUNC, TAG_VALUE, TAG_SECS: nxt = cur + 4'd1;
      TAG_ELEM:  nxt = head_i.is_num ? TAG_VALUE :
                       (head_i.fmt == FMT_TWO) ? TAG_SECS : TAG_END;
      TAG_STATE: nxt = (head_i.fmt == FMT_TWO) ? TAG_SECS : TAG_END;
      default:   nxt = TAG_END;
    endcase
    done = (cur == TAG_END) || ((cur == TAG_DESC || cur == TAG_STRING) && !head_i.is_end);
    unique case (cur)
      TAG_DESC, TAG_STRING: word = {56'd0, head_i.data};
      TAG_MODULE: word = {32'd0, head_i.keys[0]};
      TAG_LEVEL:  word = {32'd0, head_i.keys[1]};
      TAG_FUNC:   word = {32'd0, head_i.keys[2]};
      TAG_ELEM:   word = {32'd0, head_i.keys[3]};
      TAG_VALUE:  word = {32'd0, head_i.nval};
      TAG_STATE:  word = {32'd0, head_i.nstate};
      TAG_SECS:   word = head_i.secs;
      TAG_NANOS:  word = {32'd0, head_i.nanos};
      default:    word = 64'd0;
    endcase
  end

  assign adv        = head_valid_i && (!oval_q || pop_i);
  assign head_pop_o = adv && done;
  assign empty_o    = !oval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0; seq_q <= TAG_DESC; oval_q <= 1'b0;
    end else begin
      if (adv) begin
        active_q <= !done;
        seq_q    <= nxt;
        oval_q   <= 1'b1;
      end else if (pop_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_o       <= cur;
      word_o      <= word;
      status_o    <= (cur == TAG_END) ? st : ST_OK;
      format_o    <= head_i.fmt;
      is_string_o <= (head_i.fmt != FMT_NONE) && head_i.is_str;
      last_o      <= (cur == TAG_END);
    end
  end

endmodule
